/* sv/cfp_pkg.sv */
package cfp_pkg;

  // sizing of the frame buffer
  localparam int MAX_PARAMS      = 8;
  localparam int MAX_PARAM_BYTES = 32;
  localparam int CRC_BYTES       = 2;
  localparam int PLEN_BYTES      = 1;
  localparam int MIN_FRAME_LEN   = 4;
  localparam int MAX_FRAME_LEN   = MAX_PARAMS * MAX_PARAM_BYTES + 7;

  // widths derived from the buffer sizing
  localparam int LEN_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int FLEN_W = (LEN_W > 8) ? LEN_W : 8;
  localparam int SUM_W  = ((FLEN_W > 9) ? FLEN_W : 9) + 1;
  localparam int PIDX_W = $clog2(MAX_PARAMS + 1);
  localparam int SIZE_W = $clog2(MAX_PARAM_BYTES + 1);

  // fixed byte positions of the header
  localparam int POS_LEN_LO = 1;
  localparam int POS_LEN_HI = 2;
  localparam int POS_STATUS = 3;
  localparam int POS_CMD_LO = 4;
  localparam int POS_CMD_HI = 5;
  localparam int POS_COUNT  = 6;

  typedef logic [FLEN_W-1:0] flen_t;
  typedef logic [FLEN_W:0]   flen_ext_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [PIDX_W-1:0] pidx_t;
  typedef logic [SIZE_W-1:0] size_t;

  // register map index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_CHANNEL_ID = 2'd0,
    REG_MAX_COUNT  = 2'd1,
    REG_MAX_SIZE   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    PS_WAIT = 4'b0001,
    PS_RECV = 4'b0010,
    PS_DONE = 4'b0100,
    PS_DISC = 4'b1000
  } ps_t;

  typedef enum logic [1:0] {
    FS_WAITING     = 2'd0,
    FS_RECEIVING   = 2'd1,
    FS_COMPLETE    = 2'd2,
    FS_DISCARDING  = 2'd3
  } fs_t;

  typedef enum logic [3:0] {
    ROLE_CHANNEL = 4'd0,
    ROLE_LENGTH  = 4'd1,
    ROLE_STATUS  = 4'd2,
    ROLE_COMMAND = 4'd3,
    ROLE_COUNT   = 4'd4,
    ROLE_PLEN    = 4'd5,
    ROLE_PDATA   = 4'd6,
    ROLE_CRC     = 4'd7,
    ROLE_TRAIL   = 4'd8
  } role_t;

  typedef enum logic [2:0] {
    RC_OK            = 3'd0,
    RC_INVALID       = 3'd1,
    RC_EXCESS_PARAMS = 3'd2,
    RC_EXCESS_SIZE   = 3'd3,
    RC_NULL_PARAM    = 3'd4
  } rc_t;

  typedef struct packed {
    logic [7:0] channel_id;
    logic [3:0] max_param_count;
    logic [5:0] max_param_size;
  } cfg_t;

  typedef struct packed {
    ps_t         parse_state;
    flen_t       byte_count;
    flen_t       frame_len;
    logic [7:0]  declared;
    pidx_t       cur_param;
    size_t       bytes_left;
    size_t       cur_len;
    logic        in_data;
    rc_t         pend;
    logic [15:0] command;
    logic [7:0]  status;
    logic [15:0] crc;
  } state_t;

  typedef struct packed {
    logic        accepted;
    role_t       role;
    logic [2:0]  param_index;
    logic [4:0]  param_offset;
    logic        frame_done;
    rc_t         result_code;
    fs_t         frame_state;
    logic [15:0] command_id;
    logic [7:0]  frame_status;
    logic [15:0] frame_crc;
  } result_t;

endpackage

/* sv/cfp_step.sv */
module cfp_step (
  input  cfp_pkg::state_t  st,
  input  cfp_pkg::cfg_t    cfg,
  input  logic             mode,
  input  logic [7:0]       data_byte,
  output cfp_pkg::state_t  nxt,
  output cfp_pkg::result_t res
);

  logic [7:0]          count_lim;
  logic [7:0]          size_lim;
  cfp_pkg::flen_t      pos;
  cfp_pkg::flen_ext_t  pos1;
  cfp_pkg::flen_ext_t  pos2;
  cfp_pkg::flen_ext_t  flen_ext;
  logic [15:0]         full_len;
  cfp_pkg::rc_t        judged;

  // parameter length check against size limit and remaining frame room
  function automatic cfp_pkg::rc_t judge(input logic [7:0] len, input cfp_pkg::flen_t p,
                                         input cfp_pkg::flen_t fl, input logic [7:0] lim);
    cfp_pkg::sum_t s;
    begin
      s = cfp_pkg::sum_t'(p) + cfp_pkg::sum_t'(len)
        + cfp_pkg::sum_t'(cfp_pkg::PLEN_BYTES + cfp_pkg::CRC_BYTES);
      if (len > lim) begin
        judge = cfp_pkg::RC_EXCESS_SIZE;
      end else if (len == 8'd0) begin
        judge = cfp_pkg::RC_NULL_PARAM;
      end else if (s > cfp_pkg::sum_t'(fl)) begin
        judge = cfp_pkg::RC_INVALID;
      end else begin
        judge = cfp_pkg::RC_OK;
      end
    end
  endfunction

  // effective limits
  assign count_lim = (8'(cfg.max_param_count) < 8'(cfp_pkg::MAX_PARAMS)) ?
                     8'(cfg.max_param_count) : 8'(cfp_pkg::MAX_PARAMS);
  assign size_lim  = (8'(cfg.max_param_size) < 8'(cfp_pkg::MAX_PARAM_BYTES)) ?
                     8'(cfg.max_param_size) : 8'(cfp_pkg::MAX_PARAM_BYTES);

  assign pos      = st.byte_count;
  assign pos1     = cfp_pkg::flen_ext_t'(pos) + cfp_pkg::flen_ext_t'(1);
  assign pos2     = cfp_pkg::flen_ext_t'(pos) + cfp_pkg::flen_ext_t'(cfp_pkg::CRC_BYTES);
  assign flen_ext = cfp_pkg::flen_ext_t'(st.frame_len);
  assign full_len = {data_byte, st.frame_len[7:0]};
  assign judged   = judge(data_byte, pos, st.frame_len, size_lim);

  // next state and labels for one byte
  always_comb begin
    nxt = st;
    res = '0;
    res.role = cfp_pkg::ROLE_CHANNEL;
    res.result_code = cfp_pkg::RC_OK;

    if (mode) begin
      // restart clears the whole frame
      nxt.parse_state = cfp_pkg::PS_WAIT;
      nxt.byte_count  = '0;
      nxt.frame_len   = '0;
      nxt.declared    = '0;
      nxt.cur_param   = '0;
      nxt.bytes_left  = '0;
      nxt.cur_len     = '0;
      nxt.in_data     = 1'b0;
      nxt.pend        = cfp_pkg::RC_OK;
      nxt.command     = '0;
      nxt.status      = '0;
      nxt.crc         = '0;
    end else if (st.parse_state == cfp_pkg::PS_DONE || st.parse_state == cfp_pkg::PS_DISC) begin
      res.role = cfp_pkg::ROLE_TRAIL;
    end else begin
      res.accepted = 1'b1;
      if (st.parse_state == cfp_pkg::PS_WAIT) begin
        // channel byte
        if (data_byte != cfg.channel_id) begin
          nxt.parse_state = cfp_pkg::PS_DISC;
          res.frame_done  = 1'b1;
          res.result_code = cfp_pkg::RC_INVALID;
        end else begin
          nxt.parse_state = cfp_pkg::PS_RECV;
        end
      end else if (pos == cfp_pkg::flen_t'(cfp_pkg::POS_LEN_LO)) begin
        res.role      = cfp_pkg::ROLE_LENGTH;
        nxt.frame_len = cfp_pkg::flen_t'(data_byte);
      end else if (pos == cfp_pkg::flen_t'(cfp_pkg::POS_LEN_HI)) begin
        res.role = cfp_pkg::ROLE_LENGTH;
        if (full_len < 16'(cfp_pkg::MIN_FRAME_LEN) || full_len > 16'(cfp_pkg::MAX_FRAME_LEN)) begin
          nxt.parse_state = cfp_pkg::PS_DISC;
          res.frame_done  = 1'b1;
          res.result_code = cfp_pkg::RC_INVALID;
        end else begin
          nxt.frame_len = cfp_pkg::flen_t'(full_len);
          // shortest frame: length high byte doubles as crc low byte
          if (full_len == 16'(cfp_pkg::MIN_FRAME_LEN)) begin
            nxt.crc = {8'h00, data_byte};
          end
        end
      end else begin
        if (pos2 >= flen_ext) begin
          // crc bytes
          res.role = cfp_pkg::ROLE_CRC;
          if (pos2 == flen_ext) begin
            nxt.crc[7:0] = data_byte;
            if (st.pend == cfp_pkg::RC_OK && 8'(st.cur_param) < st.declared) begin
              nxt.pend = judged;
            end
          end else begin
            nxt.crc[15:8] = data_byte;
          end
        end else if (pos == cfp_pkg::flen_t'(cfp_pkg::POS_STATUS)) begin
          res.role   = cfp_pkg::ROLE_STATUS;
          nxt.status = data_byte;
        end else if (pos == cfp_pkg::flen_t'(cfp_pkg::POS_CMD_LO)) begin
          res.role         = cfp_pkg::ROLE_COMMAND;
          nxt.command[7:0] = data_byte;
        end else if (pos == cfp_pkg::flen_t'(cfp_pkg::POS_CMD_HI)) begin
          res.role          = cfp_pkg::ROLE_COMMAND;
          nxt.command[15:8] = data_byte;
        end else if (pos == cfp_pkg::flen_t'(cfp_pkg::POS_COUNT)) begin
          res.role     = cfp_pkg::ROLE_COUNT;
          nxt.declared = data_byte;
          if (data_byte > count_lim) begin
            nxt.pend = cfp_pkg::RC_EXCESS_PARAMS;
          end
        end else if (st.pend != cfp_pkg::RC_OK || 8'(st.cur_param) >= st.declared) begin
          res.role = cfp_pkg::ROLE_TRAIL;
        end else if (!st.in_data) begin
          // parameter length byte
          res.role        = cfp_pkg::ROLE_PLEN;
          res.param_index = 3'(st.cur_param);
          nxt.pend        = judged;
          if (judged == cfp_pkg::RC_OK) begin
            nxt.cur_len    = cfp_pkg::size_t'(data_byte);
            nxt.bytes_left = cfp_pkg::size_t'(data_byte);
            nxt.in_data    = 1'b1;
          end
        end else begin
          // parameter data byte
          res.role         = cfp_pkg::ROLE_PDATA;
          res.param_index  = 3'(st.cur_param);
          res.param_offset = 5'(st.cur_len - st.bytes_left);
          nxt.bytes_left   = st.bytes_left - cfp_pkg::size_t'(1);
          if (st.bytes_left == cfp_pkg::size_t'(1)) begin
            nxt.in_data   = 1'b0;
            nxt.cur_param = st.cur_param + cfp_pkg::pidx_t'(1);
          end
        end

        // last byte reports the held error
        if (pos1 == flen_ext) begin
          res.frame_done  = 1'b1;
          res.result_code = nxt.pend;
          nxt.parse_state = (nxt.pend != cfp_pkg::RC_OK) ? cfp_pkg::PS_DISC : cfp_pkg::PS_DONE;
        end
      end
      nxt.byte_count = st.byte_count + cfp_pkg::flen_t'(1);
    end

    // frame state code and captured fields after this byte
    unique case (nxt.parse_state)
      cfp_pkg::PS_WAIT: res.frame_state = cfp_pkg::FS_WAITING;
      cfp_pkg::PS_RECV: res.frame_state = cfp_pkg::FS_RECEIVING;
      cfp_pkg::PS_DONE: res.frame_state = cfp_pkg::FS_COMPLETE;
      cfp_pkg::PS_DISC: res.frame_state = cfp_pkg::FS_DISCARDING;
      default:          res.frame_state = cfp_pkg::FS_WAITING;
    endcase
    res.command_id   = nxt.command;
    res.frame_status = nxt.status;
    res.frame_crc    = nxt.crc;
  end

endmodule

/* sv/command_frame_parser.sv */
// Command frame parser: labels each received byte of a command frame with its role,
// parameter index and data offset, and reports the frame's status, command id, crc and
// result code on the frame's last byte (or at once for a wrong channel or bad length).
// One byte per clock: a byte is registered on input, labeled by one pass of the parse
// logic against the frame state and written to the result register, and a new byte can
// be taken every cycle while the result side keeps up. A restart item clears the frame.
// Registers sit on the APB port at 0x0 channel id, 0x4 max parameter count, 0x8 max
// parameter size; write them only while no byte is in flight.
module command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [3:0]  out_byte_role,
  output logic [2:0]  out_param_index,
  output logic [4:0]  out_param_offset,
  output logic        out_frame_done,
  output logic [2:0]  out_result_code,
  output logic [1:0]  out_frame_state,
  output logic [15:0] out_command_id,
  output logic [7:0]  out_frame_status,
  output logic [15:0] out_frame_crc,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfp_pkg::cfg_t    cfg_r;
  cfp_pkg::state_t  state_r;
  cfp_pkg::state_t  state_nxt;
  cfp_pkg::result_t res_nxt;
  cfp_pkg::result_t res_r;
  logic             in_vld_r;
  logic             in_mode_r;
  logic [7:0]       in_byte_r;
  logic             out_vld_r;
  logic             move;
  logic             cfg_wr;
  cfp_pkg::reg_idx_t reg_idx;

  // register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = cfp_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_id      <= 8'd0;
      cfg_r.max_param_count <= 4'd8;
      cfg_r.max_param_size  <= 6'd32;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cfp_pkg::REG_CHANNEL_ID: cfg_r.channel_id      <= pwdata[7:0];
        cfp_pkg::REG_MAX_COUNT:  cfg_r.max_param_count <= pwdata[3:0];
        cfp_pkg::REG_MAX_SIZE:   cfg_r.max_param_size  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cfp_pkg::REG_CHANNEL_ID: prdata = {24'd0, cfg_r.channel_id};
      cfp_pkg::REG_MAX_COUNT:  prdata = {28'd0, cfg_r.max_param_count};
      cfp_pkg::REG_MAX_SIZE:   prdata = {26'd0, cfg_r.max_param_size};
      default:                 prdata = 32'd0;
    endcase
  end

  // handshake: the byte in the input register moves when the result register frees up
  assign move     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !move;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_mode_r <= in_mode;
      in_byte_r <= in_data_byte;
    end
  end

  // parse logic
  cfp_step u_step (
    .st        (state_r),
    .cfg       (cfg_r),
    .mode      (in_mode_r),
    .data_byte (in_byte_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.parse_state <= cfp_pkg::PS_WAIT;
      state_r.byte_count  <= '0;
      state_r.frame_len   <= '0;
      state_r.declared    <= '0;
      state_r.cur_param   <= '0;
      state_r.bytes_left  <= '0;
      state_r.cur_len     <= '0;
      state_r.in_data     <= 1'b0;
      state_r.pend        <= cfp_pkg::RC_OK;
      state_r.command     <= '0;
      state_r.status      <= '0;
      state_r.crc         <= '0;
    end else if (move) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_accepted     = res_r.accepted;
  assign out_byte_role    = res_r.role;
  assign out_param_index  = res_r.param_index;
  assign out_param_offset = res_r.param_offset;
  assign out_frame_done   = res_r.frame_done;
  assign out_result_code  = res_r.result_code;
  assign out_frame_state  = res_r.frame_state;
  assign out_command_id   = res_r.command_id;
  assign out_frame_status = res_r.frame_status;
  assign out_frame_crc    = res_r.frame_crc;

endmodule

/* tb/cfp_frame_checker.sv */
module cfp_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_accepted,
  input  logic [3:0]  out_byte_role,
  input  logic [2:0]  out_param_index,
  input  logic [4:0]  out_param_offset,
  input  logic        out_frame_done,
  input  logic [2:0]  out_result_code,
  input  logic [1:0]  out_frame_state,
  input  logic [15:0] out_command_id,
  input  logic [7:0]  out_frame_status,
  input  logic [15:0] out_frame_crc,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [7:0]  chan_cfg;
  logic [3:0]  count_cfg;
  logic [5:0]  size_cfg;

  // frame state of the predictor
  cfp_pkg::fs_t    parse_st;
  logic [15:0]     byte_cnt;
  logic [15:0]     frame_len;
  logic [7:0]      declared;
  logic [3:0]      cur_param;
  logic [7:0]      bytes_left;
  logic [7:0]      cur_len;
  logic            in_data;
  cfp_pkg::rc_t    held_err;
  logic [15:0]     cmd_q;
  logic [7:0]      status_q;
  logic [15:0]     crc_q;

  cfp_pkg::result_t expected_labels[$];
  cfp_pkg::result_t want;

  function automatic void clear_frame();
    parse_st   = cfp_pkg::FS_WAITING;
    byte_cnt   = '0;
    frame_len  = '0;
    declared   = '0;
    cur_param  = '0;
    bytes_left = '0;
    cur_len    = '0;
    in_data    = 1'b0;
    held_err   = cfp_pkg::RC_OK;
    cmd_q      = '0;
    status_q   = '0;
    crc_q      = '0;
  endfunction

  function automatic int unsigned count_limit();
    return (int'(count_cfg) < cfp_pkg::MAX_PARAMS) ? count_cfg : cfp_pkg::MAX_PARAMS;
  endfunction

  function automatic int unsigned size_limit();
    return (int'(size_cfg) < cfp_pkg::MAX_PARAM_BYTES) ? size_cfg : cfp_pkg::MAX_PARAM_BYTES;
  endfunction

  // verdict on a parameter length byte at position pos
  function automatic cfp_pkg::rc_t judge_param_len(int unsigned len, int unsigned pos);
    if (len > size_limit()) return cfp_pkg::RC_EXCESS_SIZE;
    if (len == 0) return cfp_pkg::RC_NULL_PARAM;
    if (pos + 1 + len + 2 > frame_len) return cfp_pkg::RC_INVALID;
    return cfp_pkg::RC_OK;
  endfunction

  // label one byte and advance the frame state
  function automatic cfp_pkg::result_t label_byte(logic mode, logic [7:0] b);
    cfp_pkg::result_t r;
    int unsigned      pos;
    r = '0;
    r.role = cfp_pkg::ROLE_CHANNEL;
    r.result_code = cfp_pkg::RC_OK;
    if (mode) begin
      clear_frame();
    end else if (parse_st == cfp_pkg::FS_COMPLETE || parse_st == cfp_pkg::FS_DISCARDING) begin
      r.role = cfp_pkg::ROLE_TRAIL;
    end else begin
      pos = byte_cnt;
      r.accepted = 1'b1;
      if (parse_st == cfp_pkg::FS_WAITING) begin
        if (b != chan_cfg) begin
          parse_st = cfp_pkg::FS_DISCARDING;
          r.frame_done = 1'b1;
          r.result_code = cfp_pkg::RC_INVALID;
        end else begin
          parse_st = cfp_pkg::FS_RECEIVING;
        end
      end else if (pos == cfp_pkg::POS_LEN_LO) begin
        r.role = cfp_pkg::ROLE_LENGTH;
        frame_len = {8'h00, b};
      end else if (pos == cfp_pkg::POS_LEN_HI) begin
        r.role = cfp_pkg::ROLE_LENGTH;
        frame_len[15:8] = b;
        if (frame_len < cfp_pkg::MIN_FRAME_LEN || frame_len > cfp_pkg::MAX_FRAME_LEN) begin
          parse_st = cfp_pkg::FS_DISCARDING;
          r.frame_done = 1'b1;
          r.result_code = cfp_pkg::RC_INVALID;
        end else if (frame_len == cfp_pkg::MIN_FRAME_LEN) begin
          // shortest frame: the length high byte doubles as crc low byte
          crc_q = {8'h00, b};
        end
      end else begin
        if (pos + 2 >= frame_len) begin
          r.role = cfp_pkg::ROLE_CRC;
          if (pos + 2 == frame_len) begin
            crc_q[7:0] = b;
            // parameters still missing: crc low byte is judged as a length
            if (held_err == cfp_pkg::RC_OK && cur_param < declared)
              held_err = judge_param_len(b, pos);
          end else begin
            crc_q[15:8] = b;
          end
        end else if (pos == cfp_pkg::POS_STATUS) begin
          r.role = cfp_pkg::ROLE_STATUS;
          status_q = b;
        end else if (pos == cfp_pkg::POS_CMD_LO) begin
          r.role = cfp_pkg::ROLE_COMMAND;
          cmd_q[7:0] = b;
        end else if (pos == cfp_pkg::POS_CMD_HI) begin
          r.role = cfp_pkg::ROLE_COMMAND;
          cmd_q[15:8] = b;
        end else if (pos == cfp_pkg::POS_COUNT) begin
          r.role = cfp_pkg::ROLE_COUNT;
          declared = b;
          if (b > count_limit()) held_err = cfp_pkg::RC_EXCESS_PARAMS;
        end else if (held_err != cfp_pkg::RC_OK || cur_param >= declared) begin
          r.role = cfp_pkg::ROLE_TRAIL;
        end else if (!in_data) begin
          r.role = cfp_pkg::ROLE_PLEN;
          r.param_index = cur_param[2:0];
          held_err = judge_param_len(b, pos);
          if (held_err == cfp_pkg::RC_OK) begin
            cur_len = b;
            bytes_left = b;
            in_data = 1'b1;
          end
        end else begin
          r.role = cfp_pkg::ROLE_PDATA;
          r.param_index = cur_param[2:0];
          r.param_offset = 5'(cur_len - bytes_left);
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 0) begin
            in_data = 1'b0;
            cur_param = cur_param + 4'd1;
          end
        end
        // last byte reports the held code
        if (pos + 1 == frame_len) begin
          r.frame_done = 1'b1;
          r.result_code = held_err;
          parse_st = (held_err != cfp_pkg::RC_OK) ? cfp_pkg::FS_DISCARDING :
                     cfp_pkg::FS_COMPLETE;
        end
      end
      byte_cnt = byte_cnt + 16'd1;
    end
    r.frame_state  = parse_st;
    r.command_id   = cmd_q;
    r.frame_status = status_q;
    r.frame_crc    = crc_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    fail_count++;
  endtask

  // follow register writes, predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      chan_cfg   = 8'd0;
      count_cfg  = 4'd8;
      size_cfg   = 6'd32;
      clear_frame();
      expected_labels.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfp_pkg::reg_idx_t'(paddr[3:2]))
          cfp_pkg::REG_CHANNEL_ID: chan_cfg  = pwdata[7:0];
          cfp_pkg::REG_MAX_COUNT:  count_cfg = pwdata[3:0];
          cfp_pkg::REG_MAX_SIZE:   size_cfg  = pwdata[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_labels.push_back(label_byte(in_mode, in_data_byte));
      if (out_valid && !out_stall) begin
        if (expected_labels.size() == 0) begin
          report_mismatch("result transfer with nothing expected", 1, 0);
        end else begin
          want = expected_labels.pop_front();
          if (out_accepted !== want.accepted)
            report_mismatch("accepted", out_accepted, want.accepted);
          if (out_byte_role !== want.role)
            report_mismatch("byte_role", out_byte_role, want.role);
          if (out_param_index !== want.param_index)
            report_mismatch("param_index", out_param_index, want.param_index);
          if (out_param_offset !== want.param_offset)
            report_mismatch("param_offset", out_param_offset, want.param_offset);
          if (out_frame_done !== want.frame_done)
            report_mismatch("frame_done", out_frame_done, want.frame_done);
          if (out_result_code !== want.result_code)
            report_mismatch("result_code", out_result_code, want.result_code);
          if (out_frame_state !== want.frame_state)
            report_mismatch("frame_state", out_frame_state, want.frame_state);
          if (out_command_id !== want.command_id)
            report_mismatch("command_id", out_command_id, want.command_id);
          if (out_frame_status !== want.frame_status)
            report_mismatch("frame_status", out_frame_status, want.frame_status);
          if (out_frame_crc !== want.frame_crc)
            report_mismatch("frame_crc", out_frame_crc, want.frame_crc);
        end
      end
    end
    pending = expected_labels.size();
  end

endmodule

/* tb/tb_command_frame_parser.sv */
module tb_command_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 270;
  localparam int NUM_PHASES   = 6;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_accepted;
  logic [3:0]  out_byte_role;
  logic [2:0]  out_param_index;
  logic [4:0]  out_param_offset;
  logic        out_frame_done;
  logic [2:0]  out_result_code;
  logic [1:0]  out_frame_state;
  logic [15:0] out_command_id;
  logic [7:0]  out_frame_status;
  logic [15:0] out_frame_crc;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          cycle_cnt;
  int          items_sent;
  bit          idle_en;
  bit          stall_en;

  // stimulus copy of the registers
  int          cur_chan;
  int          cur_count;
  int          cur_size;

  command_frame_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_byte_role    (out_byte_role),
    .out_param_index  (out_param_index),
    .out_param_offset (out_param_offset),
    .out_frame_done   (out_frame_done),
    .out_result_code  (out_result_code),
    .out_frame_state  (out_frame_state),
    .out_command_id   (out_command_id),
    .out_frame_status (out_frame_status),
    .out_frame_crc    (out_frame_crc),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  cfp_frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_byte_role    (out_byte_role),
    .out_param_index  (out_param_index),
    .out_param_offset (out_param_offset),
    .out_frame_done   (out_frame_done),
    .out_result_code  (out_result_code),
    .out_frame_state  (out_frame_state),
    .out_command_id   (out_command_id),
    .out_frame_status (out_frame_status),
    .out_frame_crc    (out_frame_crc),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side stalls
  initial begin : result_side
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = stall_en ? $urandom_range(0, 3) : 0;
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one input transfer, after a random gap
  task automatic send_byte(logic mode, logic [7:0] b);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold off until every expected result has come
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(cfp_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(int chan, int count, int size);
    drain();
    repeat (4) @(negedge clk);
    apb_write(cfp_pkg::REG_CHANNEL_ID, chan);
    apb_write(cfp_pkg::REG_MAX_COUNT, count);
    apb_write(cfp_pkg::REG_MAX_SIZE, size);
    cur_chan  = chan;
    cur_count = count;
    cur_size  = size;
  endtask

  // restart, then a frame that is mostly well formed with random content
  task automatic send_frame();
    logic [7:0]  fb[$];
    int          lens[cfp_pkg::MAX_PARAMS];
    int          n_par;
    int          lim_n;
    int          lim_s;
    int          total;
    int          kind;
    int          k;
    int          cut;
    lim_n = (cur_count < cfp_pkg::MAX_PARAMS) ? cur_count : cfp_pkg::MAX_PARAMS;
    lim_s = (cur_size < cfp_pkg::MAX_PARAM_BYTES) ? cur_size : cfp_pkg::MAX_PARAM_BYTES;
    if (lim_s < 1) lim_s = 1;
    n_par = $urandom_range(0, lim_n);
    total = 9;
    for (int p = 0; p < n_par; p++) begin
      if ($urandom_range(0, 7) == 0)
        lens[p] = $urandom_range(1, lim_s);
      else
        lens[p] = $urandom_range(1, (lim_s < 4) ? lim_s : 4);
      if (total + 1 + lens[p] > cfp_pkg::MAX_FRAME_LEN)
        lens[p] = cfp_pkg::MAX_FRAME_LEN - total - 1;
      total += 1 + lens[p];
    end
    // header
    fb.push_back(8'(cur_chan));
    fb.push_back(8'(total));
    fb.push_back(8'(total >> 8));
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(8'(n_par));
    // parameters and crc
    for (int p = 0; p < n_par; p++) begin
      fb.push_back(8'(lens[p]));
      repeat (lens[p]) fb.push_back(8'($urandom));
    end
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    // occasional damage
    kind = $urandom_range(0, 99);
    if (kind >= 60 && kind < 65) begin
      fb[0] = 8'(cur_chan + $urandom_range(1, 255));
    end else if (kind < 70 && kind >= 65) begin
      fb[1] = 8'($urandom);
      fb[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    end else if (kind < 75 && kind >= 70) begin
      k = total - $urandom_range(1, total - cfp_pkg::MIN_FRAME_LEN);
      fb[1] = 8'(k);
      fb[2] = 8'(k >> 8);
    end else if (kind < 80 && kind >= 75) begin
      k = $urandom_range(1, 10);
      if (total + k > cfp_pkg::MAX_FRAME_LEN) k = cfp_pkg::MAX_FRAME_LEN - total;
      fb[1] = 8'(total + k);
      fb[2] = 8'((total + k) >> 8);
      repeat (k) fb.push_back(8'($urandom));
    end else if (kind < 85 && kind >= 80) begin
      fb[6] = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'(lim_n + $urandom_range(1, 3));
    end else if (kind < 90 && kind >= 85) begin
      if (n_par > 0)
        fb[7] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'(lim_s + $urandom_range(1, 10));
    end else if (kind < 95 && kind >= 90) begin
      fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom);
    end else if (kind >= 95) begin
      cut = $urandom_range(0, fb.size() - 1);
      fb = fb[0:cut];
    end
    // bytes past the end of the frame are ignored
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
    send_byte(1'b1, 8'($urandom));
    foreach (fb[i]) send_byte(1'b0, fb[i]);
  endtask

  // restart then random noise
  task automatic send_noise();
    send_byte(1'b1, 8'($urandom));
    repeat ($urandom_range(1, 12)) send_byte(1'b0, 8'($urandom));
  endtask

  initial begin : stimulus
    // mode bit 8, data bits 7:0
    logic [8:0] directed[$];
    int         chans[NUM_PHASES];
    int         counts[NUM_PHASES];
    int         sizes[NUM_PHASES];
    int         phase_start;
    directed = '{
      // shortest frame, then a byte after completion
      9'h100, 9'h000, 9'h004, 9'h000, 9'h0FF, 9'h0FF,
      // wrong channel, then an ignored byte
      9'h1FF, 9'h055, 9'h000,
      // length below the minimum
      9'h100, 9'h000, 9'h003, 9'h000,
      // length one above the buffer capacity
      9'h100, 9'h000, 9'h008, 9'h001,
      // largest length, cut short by a restart
      9'h100, 9'h000, 9'h007, 9'h001, 9'h0FF, 9'h000
    };
    chans  = '{0, 8'hFF, 8'h5A, 8'hA5, 8'h3C, $urandom_range(0, 255)};
    counts = '{8, 0, 8, 3, 15, $urandom_range(0, 8)};
    sizes  = '{32, 1, 32, 7, 63, $urandom_range(1, 32)};

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = 1'b0;
    in_data_byte = 8'd0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 4'd0;
    pwdata       = 32'd0;
    idle_en      = 1'b1;
    stall_en     = 1'b1;
    items_sent   = 0;
    cur_chan     = 0;
    cur_count    = 8;
    cur_size     = 32;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset register values
    foreach (directed[i]) send_byte(directed[i][8], directed[i][7:0]);

    // random part, one register setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) set_regs(chans[ph], counts[ph], sizes[ph]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        idle_en  = (ph != 1) && ($urandom_range(0, 2) != 0);
        stall_en = (ph != 1) && ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 19) == 0)
          send_noise();
        else
          send_frame();
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/cfp_pkg.sv
sv/cfp_step.sv
sv/command_frame_parser.sv
tb/cfp_frame_checker.sv
tb/tb_command_frame_parser.sv
